// ===== rtl/kwsd_pkg.sv =====
package kwsd_pkg;

  localparam int unsigned STREAMS = 16;
  localparam int unsigned WINDOW  = 64;

  localparam int unsigned SLOT_W  = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int unsigned USED_W  = $clog2(STREAMS + 1);
  localparam int unsigned IDX_W   = $clog2(WINDOW);
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);
  localparam int unsigned ADDR_W  = $clog2(STREAMS * WINDOW);
  localparam int unsigned SUM_W   = 32 + $clog2(WINDOW);
  localparam int unsigned ACC_W   = 64 + $clog2(WINDOW);
  localparam int unsigned DIV_W   = ACC_W + CNT_W;
  localparam int unsigned DVS_W   = 2 * CNT_W;
  localparam int unsigned DCNT_W  = $clog2(DIV_W);
  localparam int unsigned MULK_W  = $clog2(CNT_W);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_LOOKUP = 11'b000_0000_0010,
    ST_RDOLD  = 11'b000_0000_0100,
    ST_UPD    = 11'b000_0000_1000,
    ST_DIVM   = 11'b000_0001_0000,
    ST_ACC    = 11'b000_0010_0000,
    ST_MULN   = 11'b000_0100_0000,
    ST_SUBR   = 11'b000_1000_0000,
    ST_DIVV   = 11'b001_0000_0000,
    ST_SQRT   = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// ===== rtl/kwsd_if.sv =====
interface kwsd_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        stream_key;
  logic signed [31:0] sample;

  modport source (output valid, output stream_key, output sample, input ready);
  modport sink   (input valid, input stream_key, input sample, output ready);
endinterface

interface kwsd_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        std_dev;
  logic signed [31:0] mean;
  logic [6:0]         samples_held;
  logic               status;

  modport source (output valid, output std_dev, output mean, output samples_held,
                  output status, input ready);
  modport sink   (input valid, input std_dev, input mean, input samples_held,
                  input status, output ready);
endinterface

// ===== rtl/kwsd_div.sv =====
module kwsd_div
  import kwsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              take;

  // one quotient bit a cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    take    = (shifted >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], take};
      rem_q <= take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== rtl/keyed_window_std_dev_core.sv =====
// Keyed sliding-window standard deviation. Each input beat names a stream by
// a 32-bit key and carries one signed Q16.16 sample; every accepted beat gives
// exactly one result beat. Up to STREAMS keys are tracked, each taking the
// next free slot on first sight; once the table is full an unknown key gets
// status 1 with all other fields zero and changes nothing. Each slot holds
// its last WINDOW samples in a ring in one single-port-read sample RAM, plus
// a running sum, fill count and oldest pointer in flops. The result is the
// mean (truncated toward zero) and the exact floor of the population
// standard deviation, saturating at all ones. Items are handled one at a
// time, and the work on each is dominated by the shared bit-serial divider
// run twice (mean, then variance) and the walk over the window through the
// one RAM read port, then a 32-step square root. No clearing pass is needed
// after reset. The input is ready again as soon as a result sits in the
// output register, so a slow sink stalls only the next result, not the next
// accept.
module keyed_window_std_dev_core
  import kwsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  kwsd_in_if.sink    in_i,
  kwsd_out_if.source out_o
);

  state_e state_q;

  // slot table
  logic [31:0]        slot_keys_q [STREAMS];
  logic [USED_W-1:0]  used_q;
  logic [CNT_W-1:0]   fill_q      [STREAMS];
  logic [SUM_W-1:0]   rsum_q      [STREAMS];
  logic [IDX_W-1:0]   ptr_q       [STREAMS];

  // sample RAM
  logic [31:0]        mem [STREAMS*WINDOW];
  logic               mem_re, mem_we;
  logic [ADDR_W-1:0]  rd_addr, wr_addr, base;
  logic [31:0]        rdata_q;

  // working item
  logic [31:0]        key_q;
  logic [31:0]        x_q;
  logic [SLOT_W-1:0]  s_q;
  logic [CNT_W-1:0]   n_q;
  logic [SUM_W-1:0]   sum_q;
  logic [IDX_W-1:0]   p_q;
  logic               status_q;
  logic [31:0]        m_q;
  logic [CNT_W-1:0]   r_q;
  logic [31:0]        sd_q;

  // window walk pipeline
  logic [CNT_W-1:0]   idx_q;
  logic               rv_q, mv_q, sv_q;
  logic [31:0]        mag_q;
  logic [63:0]        sq_q;
  logic [ACC_W-1:0]   acc_q;

  // multiply by n, variance
  logic [DIV_W-1:0]   tmul_q, mcand_q;
  logic [MULK_W-1:0]  k_q;

  // square root
  logic [63:0]        v_q;
  logic [33:0]        srem_q;
  logic [31:0]        root_q;
  logic [4:0]         scnt_q;

  // output register
  logic               ovalid_q;
  logic [31:0]        osd_q, omean_q;
  logic [6:0]         oheld_q;
  logic               ostat_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  kwsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // key match over allocated slots
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < STREAMS; i++) begin
      if (!hit && (USED_W'(i) < used_q) && (slot_keys_q[i] == key_q)) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  // window update arithmetic
  logic              win_full;
  logic [SUM_W-1:0]  old_ext, x_ext, sum_new, sum_abs;
  logic [IDX_W:0]    wpos_raw;
  logic [IDX_W-1:0]  wpos, p_next;
  logic [CNT_W-1:0]  n_new;
  always_comb begin
    win_full = (n_q == CNT_W'(WINDOW));
    old_ext  = win_full ? {{(SUM_W-32){rdata_q[31]}}, rdata_q} : '0;
    x_ext    = {{(SUM_W-32){x_q[31]}}, x_q};
    sum_new  = sum_q - old_ext + x_ext;
    sum_abs  = sum_new[SUM_W-1] ? (~sum_new + 1'b1) : sum_new;
    wpos_raw = (IDX_W+1)'(p_q) + (IDX_W+1)'(n_q);
    wpos     = (wpos_raw >= (IDX_W+1)'(WINDOW)) ?
               IDX_W'(wpos_raw - (IDX_W+1)'(WINDOW)) : wpos_raw[IDX_W-1:0];
    if (win_full) begin
      p_next = (p_q == IDX_W'(WINDOW - 1)) ? '0 : p_q + 1'b1;
      n_new  = n_q;
    end else begin
      p_next = p_q;
      n_new  = n_q + 1'b1;
    end
  end

  // deviation of one window sample from the truncated mean
  logic signed [32:0] dev;
  logic [32:0]        dev_abs;
  always_comb begin
    dev     = $signed({rdata_q[31], rdata_q}) - $signed({m_q[31], m_q});
    dev_abs = dev[32] ? (~dev + 1'b1) : dev;
  end

  // square root step
  logic [33:0] s_shift, s_trial;
  logic        s_take;
  always_comb begin
    s_shift = {srem_q[31:0], v_q[63:62]};
    s_trial = {root_q, 2'b01};
    s_take  = (s_shift >= s_trial);
  end

  logic [DVS_W-1:0] r_sq, n_sq;
  assign r_sq = DVS_W'(r_q) * DVS_W'(r_q);
  assign n_sq = DVS_W'(n_q) * DVS_W'(n_q);

  // RAM ports and divider requests
  always_comb begin
    base    = ADDR_W'(ADDR_W'(s_q) * ADDR_W'(WINDOW));
    mem_re  = 1'b0;
    rd_addr = base + ADDR_W'(p_q);
    mem_we  = (state_q == ST_UPD);
    wr_addr = base + ADDR_W'(wpos);
    if (state_q == ST_RDOLD) begin
      mem_re = 1'b1;
    end else if ((state_q == ST_ACC) && (idx_q < n_q)) begin
      mem_re  = 1'b1;
      rd_addr = base + ADDR_W'(idx_q);
    end
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(sum_abs);
    div_req.divisor  = DVS_W'(n_new);
    if (state_q == ST_UPD) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_SUBR) begin
      div_req.start    = 1'b1;
      div_req.dividend = tmul_q - DIV_W'(r_sq);
      div_req.divisor  = n_sq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= x_q;
    if (mem_re) rdata_q <= mem[rd_addr];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      ovalid_q <= 1'b0;
      rv_q     <= 1'b0;
      mv_q     <= 1'b0;
      sv_q     <= 1'b0;
    end else begin
      // DONE reloads the output register itself
      if (ovalid_q && out_o.ready && (state_q != ST_DONE)) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) state_q <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          if (hit) begin
            state_q <= ST_RDOLD;
          end else if (used_q == USED_W'(STREAMS)) begin
            state_q <= ST_DONE;
          end else begin
            used_q  <= used_q + 1'b1;
            state_q <= ST_RDOLD;
          end
        end
        ST_RDOLD: state_q <= ST_UPD;
        ST_UPD:   state_q <= ST_DIVM;
        ST_DIVM: begin
          if (div_rsp.done) state_q <= ST_ACC;
        end
        ST_ACC: begin
          rv_q <= mem_re;
          mv_q <= rv_q;
          sv_q <= mv_q;
          if ((idx_q == n_q) && !rv_q && !mv_q && !sv_q) state_q <= ST_MULN;
        end
        ST_MULN: begin
          if (k_q == MULK_W'(CNT_W - 1)) state_q <= ST_SUBR;
        end
        ST_SUBR: state_q <= ST_DIVV;
        ST_DIVV: begin
          if (div_rsp.done) begin
            state_q <= (div_rsp.quotient[DIV_W-1:64] != '0) ? ST_DONE : ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (scnt_q == 5'd31) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!ovalid_q || out_o.ready) begin
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        key_q    <= in_i.stream_key;
        x_q      <= in_i.sample;
        status_q <= STATUS_OK;
      end
      ST_LOOKUP: begin
        if (hit) begin
          s_q   <= hit_slot;
          n_q   <= fill_q[hit_slot];
          sum_q <= rsum_q[hit_slot];
          p_q   <= ptr_q[hit_slot];
        end else if (used_q == USED_W'(STREAMS)) begin
          status_q <= STATUS_FULL;
        end else begin
          slot_keys_q[used_q[SLOT_W-1:0]] <= key_q;
          s_q   <= used_q[SLOT_W-1:0];
          n_q   <= '0;
          sum_q <= '0;
          p_q   <= '0;
        end
      end
      ST_RDOLD: ;
      ST_UPD: begin
        fill_q[s_q] <= n_new;
        rsum_q[s_q] <= sum_new;
        ptr_q[s_q]  <= p_next;
        n_q         <= n_new;
        sum_q       <= sum_new;
      end
      ST_DIVM: begin
        if (div_rsp.done) begin
          m_q   <= sum_q[SUM_W-1] ? (~div_rsp.quotient[31:0] + 1'b1)
                                  : div_rsp.quotient[31:0];
          r_q   <= div_rsp.remainder[CNT_W-1:0];
          idx_q <= '0;
          acc_q <= '0;
        end
      end
      ST_ACC: begin
        if (mem_re) idx_q <= idx_q + 1'b1;
        mag_q <= dev_abs[31:0];
        sq_q  <= 64'(mag_q) * 64'(mag_q);
        if (sv_q) acc_q <= acc_q + ACC_W'(sq_q);
        tmul_q  <= '0;
        mcand_q <= DIV_W'(acc_q) + (sv_q ? DIV_W'(sq_q) : '0);
        k_q     <= '0;
      end
      ST_MULN: begin
        if (n_q[k_q]) tmul_q <= tmul_q + mcand_q;
        mcand_q <= {mcand_q[DIV_W-2:0], 1'b0};
        k_q     <= k_q + 1'b1;
      end
      ST_SUBR: ;
      ST_DIVV: begin
        v_q    <= div_rsp.quotient[63:0];
        srem_q <= '0;
        root_q <= '0;
        scnt_q <= '0;
        sd_q   <= '1;
      end
      ST_SQRT: begin
        v_q    <= {v_q[61:0], 2'b00};
        srem_q <= s_take ? (s_shift - s_trial) : s_shift;
        root_q <= {root_q[30:0], s_take};
        scnt_q <= scnt_q + 1'b1;
        sd_q   <= {root_q[30:0], s_take};
      end
      ST_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          ostat_q <= status_q;
          if (status_q == STATUS_FULL) begin
            osd_q   <= '0;
            omean_q <= '0;
            oheld_q <= '0;
          end else begin
            osd_q   <= sd_q;
            omean_q <= m_q;
            oheld_q <= 7'(n_q);
          end
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = ovalid_q;
  assign out_o.std_dev      = osd_q;
  assign out_o.mean         = omean_q;
  assign out_o.samples_held = oheld_q;
  assign out_o.status       = ostat_q;

endmodule

// ===== rtl/kwsd_checker.sv =====
module kwsd_checker
  import kwsd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] std_dev_i,
  input logic [31:0] mean_i,
  input logic [6:0]  samples_held_i,
  input logic        status_i
);

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted twice in a row");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> std_dev_i == '0 && mean_i == '0 && samples_held_i == '0)
    else $error("table-full beat carries data");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !status_i |-> samples_held_i != '0 && samples_held_i <= 7'(WINDOW))
    else $error("samples_held out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(std_dev_i) && $stable(mean_i))
    else $error("stalled result beat changed");

endmodule

bind keyed_window_std_dev_core kwsd_checker u_kwsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .std_dev_i      (out_o.std_dev),
  .mean_i         (out_o.mean),
  .samples_held_i (out_o.samples_held),
  .status_i       (out_o.status)
);

// ===== verif/keyed_window_std_dev_core_chk.sv =====
`timescale 1ns / 100ps

module keyed_window_std_dev_core_chk
  import kwsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  kwsd_in_if.sink    in_i,
  kwsd_out_if.sink   out_o,
  output int         fail_count_o,
  output int         results_seen_o,
  output int         pending_o
);

  typedef struct {
    logic [31:0] std_dev;
    logic [31:0] mean;
    logic [6:0]  held;
    logic        status;
  } stat_t;

  logic [31:0]        key_tab [STREAMS];
  int unsigned        keys_used;
  int unsigned        fill [STREAMS];
  longint             win_sum [STREAMS];
  int unsigned        oldest [STREAMS];
  logic signed [31:0] ring [STREAMS][WINDOW];
  stat_t              stats_due[$];

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0]  res;
    logic [127:0] sq;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      sq = 128'(res | (64'd1 << b));
      if (sq * sq <= v) res = res | (64'd1 << b);
    end
    return res;
  endfunction

  // Work out the window statistics after one sample enters its stream.
  task automatic update_stream(input logic [31:0] key, input logic signed [31:0] x);
    int          s;
    longint      n, m, r, d;
    logic [127:0] acc, rr;
    logic [63:0]  sd;
    stat_t       st;
    s = -1;
    for (int i = 0; i < keys_used; i++)
      if (s < 0 && key_tab[i] == key) s = i;
    if (s < 0) begin
      if (keys_used >= STREAMS) begin
        st = '{32'd0, 32'd0, 7'd0, STATUS_FULL};
        stats_due.push_back(st);
        return;
      end
      s = keys_used++;
      key_tab[s] = key;
      fill[s] = 0;
      win_sum[s] = 0;
      oldest[s] = 0;
    end
    if (fill[s] < WINDOW) begin
      ring[s][(oldest[s] + fill[s]) % WINDOW] = x;
      fill[s]++;
    end else begin
      win_sum[s] -= ring[s][oldest[s]];
      ring[s][oldest[s]] = x;
      oldest[s] = (oldest[s] + 1) % WINDOW;
    end
    win_sum[s] += x;
    n = fill[s];
    m = win_sum[s] / n;
    r = win_sum[s] - m * n;
    acc = '0;
    for (int i = 0; i < n; i++) begin
      d = longint'(ring[s][i]) - m;
      if (d < 0) d = -d;
      acc += 128'(d) * 128'(d);
    end
    rr = 128'(r < 0 ? -r : r);
    acc = (acc * 128'(n) - rr * rr) / 128'(n) / 128'(n);
    if (acc[127:64] != 0) sd = 64'hFFFF_FFFF;
    else begin
      sd = isqrt(acc);
      if (sd > 64'hFFFF_FFFF) sd = 64'hFFFF_FFFF;
    end
    st = '{sd[31:0], m[31:0], n[6:0], STATUS_OK};
    stats_due.push_back(st);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stat_t e;
    if (!rst_ni) begin
      keys_used <= 0;
      stats_due.delete();
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (in_i.valid && in_i.ready) update_stream(in_i.stream_key, in_i.sample);
      if (out_o.valid && out_o.ready) begin
        results_seen_o <= results_seen_o + 1;
        if (stats_due.size() == 0) begin
          $error("unexpected result beat");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = stats_due.pop_front();
          if (out_o.std_dev !== e.std_dev || out_o.mean !== e.mean ||
              out_o.samples_held !== e.held || out_o.status !== e.status) begin
            fail_count_o <= fail_count_o + 1;
            if (out_o.std_dev !== e.std_dev)
              $error("std_dev exp %h got %h", e.std_dev, out_o.std_dev);
            if (out_o.mean !== e.mean)
              $error("mean exp %h got %h", e.mean, out_o.mean);
            if (out_o.samples_held !== e.held)
              $error("samples_held exp %0d got %0d", e.held, out_o.samples_held);
            if (out_o.status !== e.status)
              $error("status exp %0d got %0d", e.status, out_o.status);
          end
        end
      end
    end
  end

  assign pending_o = stats_due.size();

endmodule

// ===== verif/keyed_window_std_dev_core_tb.sv =====
`timescale 1ns / 100ps

module keyed_window_std_dev_core_tb;
  import kwsd_pkg::*;

  localparam int RANDOM_BEATS = 1500;
  localparam int STALL_LIMIT  = 20000;   // cycles without a beat on either side

  logic clk_i;
  logic rst_ni;
  int   fail_count, results_seen, pending;
  int   idle_cycles;
  int   beats_sent;
  int   full_seen;

  kwsd_in_if  in_ch ();
  kwsd_out_if out_ch ();

  keyed_window_std_dev_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  keyed_window_std_dev_core_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_ch.sink),
    .out_o         (out_ch.sink),
    .fail_count_o  (fail_count),
    .results_seen_o(results_seen),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Sink stalls: alternating stretches of always-ready and random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    int phase;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      phase = 0;
    end else begin
      phase = (phase + 1) % 700;
      if (phase < 200) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL keyed_window_std_dev_core");
        $finish;
      end
    end
  end

  int unsigned gap_left;

  // Drive one beat and hold it until accepted; random gap afterwards in bursts.
  task automatic send_beat(input logic [31:0] key, input logic signed [31:0] x);
    if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    in_ch.valid      <= 1'b1;
    in_ch.stream_key <= key;
    in_ch.sample     <= x;
    do @(posedge clk_i); while (!in_ch.ready);
    beats_sent++;
    if ($urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 300);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom();
    endcase
  endfunction

  logic [31:0] keys [16];

  initial begin
    int k;
    in_ch.valid      <= 1'b0;
    in_ch.stream_key <= '0;
    in_ch.sample     <= '0;
    rst_ni = 1'b0;
    beats_sent = 0;
    gap_left = 0;
    full_seen = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zero key, all-ones key, opposite extremes in one window.
    send_beat(32'h0000_0000, 32'h7FFF_FFFF);
    send_beat(32'h0000_0000, 32'h8000_0000);
    send_beat(32'hFFFF_FFFF, 32'h8000_0000);
    send_beat(32'hFFFF_FFFF, 32'h8000_0000);
    send_beat(32'h0000_0000, 32'h0000_0000);
    send_beat(32'h1234_5678, 32'hFFFF_FFFF);  // -1 lsb, mean truncation
    send_beat(32'h1234_5678, 32'h0000_0000);
    send_beat(32'h1234_5678, 32'hFFFF_0000);  // constant -1.0
    // Pressure: sender holds off until every result is back.
    drain();
    // Fill the table to 16 keys, then an unknown key hits table full.
    for (int i = 3; i < 16; i++) send_beat(32'hA500_0000 + i, 32'h0001_0000 * i);
    send_beat(32'hDEAD_BEEF, 32'h7FFF_FFFF);
    send_beat(32'hDEAD_BEEF, 32'h8000_0000);
    full_seen += 2;
    drain();

    // Random: mostly known keys (window wraps), some unknown keys (table full).
    keys[0] = 32'h0; keys[1] = 32'hFFFF_FFFF; keys[2] = 32'h1234_5678;
    for (int i = 3; i < 16; i++) keys[i] = 32'hA500_0000 + i;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_beat($urandom() | 32'h0000_0100, rand_sample());
        full_seen++;
      end else begin
        k = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2) : $urandom_range(0, 15);
        send_beat(keys[k], rand_sample());
      end
      if (i == RANDOM_BEATS / 2) drain();
    end
    drain();
    repeat (300) @(posedge clk_i);

    $display("Covered %0d beats over 16 streams with window wrap, %0d unknown-key beats",
             beats_sent, full_seen);
    $display("and %0d result beats checked under random source gaps and sink stalls.",
             results_seen);
    if (fail_count == 0 && pending == 0) $display("PASS keyed_window_std_dev_core");
    else $display("FAIL keyed_window_std_dev_core");
    $finish;
  end

endmodule
